// ===== hw/rtl/hbf_pkg.sv =====
// Shared types and constants for the HTTP header block framer.
`default_nettype none

package hbf_pkg;

  localparam logic [7:0]  CharCr        = 8'h0D;
  localparam logic [7:0]  CharLf        = 8'h0A;
  localparam logic [23:0] ByteTotalSat  = 24'hFFFFFF;
  localparam logic [16:0] LineBytesSat  = 17'h1FFFF;
  localparam logic [8:0]  FieldTotalSat = 9'h1FF;
  localparam logic [23:0] TermTrim      = 24'd2;
  localparam logic [23:0] CapExtra      = 24'd4;

  localparam logic [15:0] MaxLineLengthRst  = 16'd8190;
  localparam logic [7:0]  MaxFieldsRst      = 8'd100;
  localparam logic [15:0] MaxFieldLengthRst = 16'd8190;

  typedef enum logic [1:0] {
    CFG_MAX_LINE_LENGTH  = 2'd0,
    CFG_MAX_FIELDS       = 2'd1,
    CFG_MAX_FIELD_LENGTH = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    FAULT_NONE       = 3'd0,
    FAULT_LINE_LONG  = 3'd1,
    FAULT_FIELD_LONG = 3'd2,
    FAULT_TOO_MANY   = 3'd3,
    FAULT_CAP        = 3'd4,
    FAULT_ABORT      = 3'd5
  } fault_e;

  // terminator matcher; the final LF is never stored, it ends the request
  typedef enum logic [1:0] {
    MATCH_NONE   = 2'd0,
    MATCH_CR     = 2'd1,
    MATCH_CRLF   = 2'd2,
    MATCH_CRLFCR = 2'd3
  } match_e;

  typedef struct packed {
    logic [15:0] max_line_length;
    logic [7:0]  max_fields;
    logic [15:0] max_field_length;
    logic [23:0] byte_cap;
  } limits_t;

  typedef struct packed {
    logic        accepted;
    logic [23:0] header_length;
    fault_e      fault_code;
  } verdict_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hbf_cap.sv =====
// Configuration registers and the pipelined byte cap computation.
`default_nettype none

module hbf_cap
  import hbf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output limits_t          limits_o,
  output logic             busy_o
);

  logic [15:0] max_line_length_q;
  logic [7:0]  max_fields_q;
  logic [15:0] max_field_length_q;
  logic [23:0] prod_q, prod_d;
  logic [23:0] cap_q, cap_d;
  logic [1:0]  busy_q, busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_length_q  <= MaxLineLengthRst;
      max_fields_q       <= MaxFieldsRst;
      max_field_length_q <= MaxFieldLengthRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_MAX_LINE_LENGTH:  max_line_length_q  <= cfg_data_i;
        CFG_MAX_FIELDS:       max_fields_q       <= cfg_data_i[7:0];
        CFG_MAX_FIELD_LENGTH: max_field_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // two stages: product, then sum; busy covers the fill
  assign prod_d = {16'd0, max_fields_q} * {8'd0, max_field_length_q};
  assign cap_d  = {8'd0, max_line_length_q} + prod_q + CapExtra;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    cap_q  <= cap_d;
  end

  always_comb begin
    if (cfg_valid_i) begin
      busy_d = 2'd2;
    end else if (busy_q != 2'd0) begin
      busy_d = busy_q - 2'd1;
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 2'd2;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign busy_o                    = (busy_q != 2'd0);
  assign limits_o.max_line_length  = max_line_length_q;
  assign limits_o.max_fields       = max_fields_q;
  assign limits_o.max_field_length = max_field_length_q;
  assign limits_o.byte_cap         = cap_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hbf_scan.sv =====
// Per-request scan state: terminator matcher, line and field counters, verdict.
`default_nettype none

module hbf_scan
  import hbf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       abort_i,
  input  wire limits_t    limits_i,
  output logic            verdict_valid_o,
  output verdict_t        verdict_o
);

  logic [23:0] byte_total_q, byte_total_d, byte_inc;
  logic [16:0] line_bytes_q, line_bytes_d, line_inc;
  logic [8:0]  field_total_q, field_total_d;
  logic        in_req_q, in_req_d;
  match_e      match_q, match_d;
  fault_e      fault_q, fault_d;
  logic        is_cr, is_lf, line_end, term, verdict;

  always_comb begin
    byte_inc = (byte_total_q != ByteTotalSat) ? byte_total_q + 24'd1 : byte_total_q;
    line_inc = (line_bytes_q != LineBytesSat) ? line_bytes_q + 17'd1 : line_bytes_q;
    is_cr    = (data_byte_i == CharCr);
    is_lf    = (data_byte_i == CharLf);
    line_end = is_lf && (match_q == MATCH_CR);
    term     = is_lf && (match_q == MATCH_CRLFCR);

    if (is_cr) begin
      match_d = (match_q == MATCH_CRLF) ? MATCH_CRLFCR : MATCH_CR;
    end else if (line_end) begin
      match_d = MATCH_CRLF;
    end else begin
      match_d = MATCH_NONE;
    end

    byte_total_d  = byte_inc;
    line_bytes_d  = line_inc;
    field_total_d = field_total_q;
    in_req_d      = in_req_q;
    fault_d       = fault_q;

    if (line_end) begin
      if (in_req_q) begin
        if (line_inc > {1'b0, limits_i.max_line_length} && fault_q == FAULT_NONE) begin
          fault_d = FAULT_LINE_LONG;
        end
        in_req_d = 1'b0;
      end else begin
        if (field_total_q != FieldTotalSat) begin
          field_total_d = field_total_q + 9'd1;
        end
        if (line_inc > {1'b0, limits_i.max_field_length} && fault_q == FAULT_NONE) begin
          fault_d = FAULT_FIELD_LONG;
        end
      end
      line_bytes_d = 17'd0;
    end

    verdict                 = 1'b1;
    verdict_o.accepted      = 1'b0;
    verdict_o.header_length = 24'd0;
    if (abort_i) begin
      verdict_o.fault_code = FAULT_ABORT;
    end else if (term) begin
      if (fault_d != FAULT_NONE) begin
        verdict_o.fault_code = fault_d;
      end else if (field_total_d > {1'b0, limits_i.max_fields}) begin
        verdict_o.fault_code = FAULT_TOO_MANY;
      end else begin
        verdict_o.accepted      = 1'b1;
        verdict_o.header_length = byte_inc - TermTrim;
        verdict_o.fault_code    = FAULT_NONE;
      end
    end else if (byte_inc >= limits_i.byte_cap) begin
      verdict_o.fault_code = FAULT_CAP;
    end else begin
      verdict              = 1'b0;
      verdict_o.fault_code = FAULT_NONE;
    end

    // any verdict starts a fresh request
    if (verdict) begin
      byte_total_d  = 24'd0;
      line_bytes_d  = 17'd0;
      field_total_d = 9'd0;
      in_req_d      = 1'b1;
      match_d       = MATCH_NONE;
      fault_d       = FAULT_NONE;
    end

    verdict_valid_o = step_i && verdict;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_total_q  <= 24'd0;
      line_bytes_q  <= 17'd0;
      field_total_q <= 9'd0;
      in_req_q      <= 1'b1;
      match_q       <= MATCH_NONE;
      fault_q       <= FAULT_NONE;
    end else if (step_i) begin
      byte_total_q  <= byte_total_d;
      line_bytes_q  <= line_bytes_d;
      field_total_q <= field_total_d;
      in_req_q      <= in_req_d;
      match_q       <= match_d;
      fault_q       <= fault_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/http_header_block_framer.sv =====
// Top level of the HTTP header block framer: input register, scan, output register.
`default_nettype none

// Takes a request one byte per transaction and finds the first CR LF CR LF
// that ends its header block. The first line is checked against
// max_line_length and every later line is counted as a header field and
// checked against max_field_length (lengths include CR LF). The terminator
// must end within max_line_length + max_fields * max_field_length + 4 bytes.
// A verdict transaction is produced at the terminator (accepted, with the
// length through the first CR LF of the terminator, unless a line, field
// or field count limit was broken), when the byte cap is reached, or when
// abort is set on an input transaction; the next byte then starts a new
// request. Bytes that cause no verdict produce no output. Throughput is
// one byte per clock while in_stall_o is low: each byte is registered at
// the input, run through the matcher and counters, and any verdict lands
// in the output register. The cap is computed by a two-stage multiply/add
// behind the config registers; after each config write, and after reset,
// in_stall_o is held high while that pipeline refills. Config writes are
// always taken (cfg_ready_o is tied high); index 3 is ignored.
module http_header_block_framer
  import hbf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        abort_i,
  // verdict output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic [23:0]      header_length_o,
  output logic [2:0]       fault_code_o
);

  limits_t  limits;
  logic     cap_busy;
  logic     s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic     s1_abort_q;
  logic     in_take, advance;
  logic     verdict_valid;
  verdict_t verdict;
  logic     out_valid_q, out_valid_d;
  verdict_t out_q;

  assign cfg_ready_o = 1'b1;

  hbf_cap u_cap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .limits_o    (limits),
    .busy_o      (cap_busy)
  );

  // the input stage moves on when it holds a byte, the cap is not refilling, and the output slot is free or draining
  assign advance    = s1_valid_q && !cap_busy && (!out_valid_q || !out_stall_i);
  assign in_stall_o = cap_busy || (s1_valid_q && out_valid_q && out_stall_i);
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= data_byte_i;
      s1_abort_q <= abort_i;
    end
  end

  hbf_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .data_byte_i     (s1_byte_q),
    .abort_i         (s1_abort_q),
    .limits_i        (limits),
    .verdict_valid_o (verdict_valid),
    .verdict_o       (verdict)
  );

  always_comb begin
    if (verdict_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict_valid) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_q.accepted;
  assign header_length_o = out_q.header_length;
  assign fault_code_o    = out_q.fault_code;

  // an accepted header carries no fault code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> fault_code_o == FAULT_NONE)
    else $error("accepted verdict with a fault code");

  // a rejection has zero length and a real fault code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> header_length_o == 24'd0 && fault_code_o != FAULT_NONE)
    else $error("rejection with length or without fault");

  // no byte is scanned against a stale cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_busy |-> !advance)
    else $error("byte scanned while cap pipeline refills");

  // a verdict is never loaded over one that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !verdict_valid)
    else $error("verdict overwrote a stalled output");

endmodule

`default_nettype wire
